// ===== rtl/core/avm_pkg.sv =====
// ----------------------------------------------------------------------------
// Averaging voltmeter package
// Shared widths, input codes, the stage record and the digit helpers.
// ----------------------------------------------------------------------------
package avm_pkg;

  localparam int unsigned SAMPLES_PER_MEAN = 8;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned COUNT_W  = $clog2(SAMPLES_PER_MEAN);
  localparam int unsigned SUM_W    = SAMPLE_W + COUNT_W;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned VOLT_W   = 6;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned SCALE_W  = 17;
  localparam int unsigned SCALE_SH = 10;

  localparam logic [SCALE_W-1:0] SCALE_MUL  = SCALE_W'(33);
  localparam logic [SCALE_W-1:0] SCALE_BIAS = SCALE_W'(511);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                tick;
    logic                update;
    logic [SAMPLE_W-1:0] mean;
  } stage_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [DIGIT_W-1:0] tens_digit(input logic [VOLT_W-1:0] v);
    logic [DIGIT_W-1:0] t;
    if (v >= VOLT_W'(60)) begin
      t = DIGIT_W'(6);
    end else if (v >= VOLT_W'(50)) begin
      t = DIGIT_W'(5);
    end else if (v >= VOLT_W'(40)) begin
      t = DIGIT_W'(4);
    end else if (v >= VOLT_W'(30)) begin
      t = DIGIT_W'(3);
    end else if (v >= VOLT_W'(20)) begin
      t = DIGIT_W'(2);
    end else if (v >= VOLT_W'(10)) begin
      t = DIGIT_W'(1);
    end else begin
      t = DIGIT_W'(0);
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/avm_accum.sv =====
// ----------------------------------------------------------------------------
// Averaging voltmeter accumulator
// Input register, group accumulator and the stage register toward the display.
// ----------------------------------------------------------------------------
module avm_accum (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [avm_pkg::SAMPLE_W-1:0]    sample_i,
  output avm_pkg::stage_t                 stage_o,
  input  logic                            stage_ready_i
);

  logic                         in_valid_q;
  logic                         in_kind_q;
  logic [avm_pkg::SAMPLE_W-1:0] in_sample_q;
  logic [avm_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [avm_pkg::COUNT_W-1:0]  count_q, count_d;
  avm_pkg::stage_t              stage_q, stage_d;
  logic                         s1_move;
  logic                         last;
  logic [avm_pkg::SUM_W-1:0]    sum_total;

  assign s1_move    = in_valid_q && stage_ready_i;
  assign in_ready_o = !in_valid_q || stage_ready_i;
  assign sum_total  = sum_q + avm_pkg::SUM_W'(in_sample_q);
  assign last       = (count_q == avm_pkg::COUNT_W'(avm_pkg::SAMPLES_PER_MEAN - 1));

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    stage_d = stage_q;
    if (stage_ready_i) begin
      stage_d.valid  = in_valid_q;
      stage_d.tick   = (in_kind_q == avm_pkg::KIND_TICK);
      stage_d.update = 1'b0;
      stage_d.mean   = avm_pkg::SAMPLE_W'(sum_total / avm_pkg::SAMPLES_PER_MEAN);
    end
    if (s1_move && (in_kind_q == avm_pkg::KIND_SAMPLE)) begin
      if (last) begin
        sum_d          = '0;
        count_d        = '0;
        stage_d.update = 1'b1;
      end else begin
        sum_d   = sum_total;
        count_d = count_q + avm_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sum_q      <= '0;
      count_q    <= '0;
      stage_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      sum_q   <= sum_d;
      count_q <= count_d;
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_kind_q   <= kind_i;
      in_sample_q <= sample_i;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== rtl/core/avm_display.sv =====
// ----------------------------------------------------------------------------
// Averaging voltmeter display stage
// Voltage scaling, held value, digit multiplexing and the result register.
// ----------------------------------------------------------------------------
module avm_display (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  avm_pkg::stage_t               stage_i,
  output logic                          stage_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [avm_pkg::SEG_W-1:0]     segments_o,
  output logic                          digit_select_o,
  output logic [avm_pkg::VOLT_W-1:0]    volts_tenths_o
);

  logic [avm_pkg::VOLT_W-1:0]  held_q;
  logic                        high_next_q;
  logic                        out_valid_q;
  logic [avm_pkg::SEG_W-1:0]   seg_q;
  logic                        sel_q;
  logic [avm_pkg::VOLT_W-1:0]  volts_q;
  logic                        out_free;
  logic                        consume;
  logic [avm_pkg::SCALE_W-1:0] scaled;
  logic [avm_pkg::SCALE_W-1:0] rounded;
  logic [avm_pkg::VOLT_W-1:0]  new_volts;
  logic [avm_pkg::DIGIT_W-1:0] tens;
  logic [avm_pkg::DIGIT_W-1:0] units;
  logic [avm_pkg::VOLT_W-1:0]  tens_ten;

  assign out_free      = !out_valid_q || out_ready_i;
  assign consume       = stage_i.valid && (!stage_i.tick || out_free);
  assign stage_ready_o = !stage_i.valid || consume;

  // Division by 1023 is done as (x + (x >> 10) + 1) >> 10, exact for this range.
  assign scaled    = avm_pkg::SCALE_W'(stage_i.mean) * avm_pkg::SCALE_MUL
                   + avm_pkg::SCALE_BIAS;
  assign rounded   = scaled + (scaled >> avm_pkg::SCALE_SH) + avm_pkg::SCALE_W'(1);
  assign new_volts = avm_pkg::VOLT_W'(rounded >> avm_pkg::SCALE_SH);

  assign tens     = avm_pkg::tens_digit(held_q);
  assign tens_ten = avm_pkg::VOLT_W'({tens, 3'b000}) + avm_pkg::VOLT_W'({tens, 1'b0});
  assign units    = avm_pkg::DIGIT_W'(held_q - tens_ten);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      high_next_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (consume && stage_i.update) begin
        held_q <= new_volts;
      end
      if (consume && stage_i.tick) begin
        out_valid_q <= 1'b1;
        high_next_q <= !high_next_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && stage_i.tick) begin
      seg_q   <= avm_pkg::seg_pattern(high_next_q ? tens : units);
      sel_q   <= high_next_q;
      volts_q <= held_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;
  assign volts_tenths_o = volts_q;

endmodule

// ===== rtl/core/averaging_voltmeter_display.sv =====
// ----------------------------------------------------------------------------
// Averaging voltmeter display
// Averages converter samples in groups and drives a two-digit display.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while in_ready_o is high. A refresh tick
// presents its display word after passing through the input register, the
// accumulator stage register and the result register; samples yield no word.
// When the result register is held by the consumer, ticks stall there and the
// stall moves back through the two earlier registers, while samples keep
// flowing past a waiting result.
module averaging_voltmeter_display (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [avm_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [avm_pkg::SEG_W-1:0]     segments_o,
  output logic                          digit_select_o,
  output logic [avm_pkg::VOLT_W-1:0]    volts_tenths_o
);

  avm_pkg::stage_t stage;
  logic            stage_ready;

  avm_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .sample_i      (sample_i),
    .stage_o       (stage),
    .stage_ready_i (stage_ready)
  );

  avm_display u_display (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (stage),
    .stage_ready_o  (stage_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o),
    .volts_tenths_o (volts_tenths_o)
  );

endmodule
